### sv/multi_knapsack_evaluate_repair_core_macros.svh
// Assertion macros used by the checker file of the knapsack evaluate/repair core.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef MULTI_KNAPSACK_EVALUATE_REPAIR_CORE_MACROS_SVH
`define MULTI_KNAPSACK_EVALUATE_REPAIR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MKER_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knapsack core check failed");

// Next-cycle implication, disabled during reset.
`define MKER_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knapsack core check failed");

`endif

### sv/mker_pkg.sv
// Package of the knapsack evaluate/repair core: sizes, codes and channel types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mker_pkg;

    localparam int MAX_ITEMS     = 64;
    localparam int MAX_CONS      = 8;
    localparam int VALUE_BITS    = 16;
    localparam int ITEM_BITS     = $clog2(MAX_ITEMS);
    localparam int ITEM_CNT_BITS = $clog2(MAX_ITEMS + 1);
    localparam int CONS_CNT_BITS = $clog2(MAX_CONS + 1);
    localparam int SUM_BITS      = VALUE_BITS + ITEM_BITS;
    localparam int FIT_BITS      = 22;
    localparam int ACC_BITS      = (SUM_BITS > FIT_BITS) ? SUM_BITS : FIT_BITS + 1;
    localparam logic [FIT_BITS-1:0] FIT_MAX = {FIT_BITS{1'b1}};

    localparam logic [2:0] KIND_LOAD_PROFIT = 3'd0;
    localparam logic [2:0] KIND_LOAD_WEIGHT = 3'd1;
    localparam logic [2:0] KIND_LOAD_CAP    = 3'd2;
    localparam logic [2:0] KIND_EVALUATE    = 3'd3;
    localparam logic [2:0] KIND_REPAIR      = 3'd4;

    localparam logic CFG_ITEMS = 1'b0;
    localparam logic CFG_CONS  = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  item_index;
        logic [2:0]  constraint_index;
        logic [15:0] load_value;
        logic [63:0] genes;
    } req_t;

    typedef struct packed {
        logic [21:0] fitness;
        logic        feasible;
        logic [63:0] repaired_genes;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BACK,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                     load;
        logic                     start;
        logic                     issue;
        logic                     back;
        logic [ITEM_BITS-1:0]     addr;
        logic                     finish;
        logic                     repair;
        logic [ITEM_CNT_BITS-1:0] ni;
        logic [CONS_CNT_BITS-1:0] nc;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### sv/mker_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mker_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/mker_ctrl.sv
// Controller of the knapsack core: configuration registers and the pass sequencer.
// Depends on mker_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mker_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire mker_pkg::req_t req,
    output logic               req_stall,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [6:0]    cfg_data,
    input  wire mker_pkg::sts_t sts,
    output mker_pkg::cmd_t     cmd
);

    mker_pkg::state_t state_reg, state_next;
    logic [mker_pkg::ITEM_BITS-1:0]     idx_reg, idx_next;
    logic                               repair_reg, repair_next;
    logic [6:0]                         items_reg;
    logic [3:0]                         cons_reg;
    logic [mker_pkg::ITEM_CNT_BITS-1:0] ni;
    logic [mker_pkg::CONS_CNT_BITS-1:0] nc;
    logic                               accept;

    // Out-of-range counts are clamped to the nearest legal value.
    always_comb
    begin
        if (items_reg == '0)
            ni = mker_pkg::ITEM_CNT_BITS'(1);
        else if (32'(items_reg) > mker_pkg::MAX_ITEMS)
            ni = mker_pkg::ITEM_CNT_BITS'(mker_pkg::MAX_ITEMS);
        else
            ni = mker_pkg::ITEM_CNT_BITS'(items_reg);
        if (cons_reg == '0)
            nc = mker_pkg::CONS_CNT_BITS'(1);
        else if (32'(cons_reg) > mker_pkg::MAX_CONS)
            nc = mker_pkg::CONS_CNT_BITS'(mker_pkg::MAX_CONS);
        else
            nc = mker_pkg::CONS_CNT_BITS'(cons_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg <= 7'd64;
            cons_reg  <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mker_pkg::CFG_ITEMS: items_reg <= cfg_data;
                mker_pkg::CFG_CONS:  cons_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mker_pkg::ST_IDLE;
            idx_reg    <= '0;
            repair_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            repair_reg <= repair_next;
        end
    end

    assign req_stall = (state_reg != mker_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        repair_next = repair_reg;
        cmd         = '0;
        cmd.addr    = idx_reg;
        cmd.repair  = repair_reg;
        cmd.ni      = ni;
        cmd.nc      = nc;
        case (state_reg)
            mker_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind inside {mker_pkg::KIND_LOAD_PROFIT, mker_pkg::KIND_LOAD_WEIGHT,
                                         mker_pkg::KIND_LOAD_CAP})
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (req.kind inside {mker_pkg::KIND_EVALUATE, mker_pkg::KIND_REPAIR})
                    begin
                        cmd.start   = 1'b1;
                        repair_next = (req.kind == mker_pkg::KIND_REPAIR);
                        idx_next    = '0;
                        state_next  = mker_pkg::ST_FWD;
                    end
                end
            end
            mker_pkg::ST_FWD:
            begin
                cmd.issue = 1'b1;
                if (mker_pkg::ITEM_CNT_BITS'(idx_reg) + 1'b1 == ni)
                begin
                    if (repair_reg)
                    begin
                        idx_next   = mker_pkg::ITEM_BITS'(ni - 1'b1);
                        state_next = mker_pkg::ST_BACK;
                    end
                    else
                    begin
                        state_next = mker_pkg::ST_WAIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mker_pkg::ST_BACK:
            begin
                cmd.issue = 1'b1;
                cmd.back  = 1'b1;
                if (idx_reg == '0)
                    state_next = mker_pkg::ST_WAIT;
                else
                    idx_next = idx_reg - 1'b1;
            end
            mker_pkg::ST_WAIT:
            begin
                state_next = mker_pkg::ST_DONE;
            end
            mker_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = mker_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mker_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/mker_dp.sv
// Datapath of the knapsack core: tables, per-constraint sums, gene mask and result register.
// Depends on mker_pkg and mker_ram.
`timescale 1ns / 1ps
`default_nettype none
module mker_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mker_pkg::req_t req,
    input  wire mker_pkg::cmd_t cmd,
    output mker_pkg::sts_t      sts,
    input  wire logic           rsp_stall,
    output logic                rsp_valid,
    output mker_pkg::rsp_t      rsp
);

    localparam int NC = mker_pkg::MAX_CONS;
    localparam int NI = mker_pkg::MAX_ITEMS;
    localparam int VB = mker_pkg::VALUE_BITS;
    localparam int AB = mker_pkg::ACC_BITS;

    logic [VB-1:0]  w_rd [NC];
    logic [VB-1:0]  p_rd;
    logic [VB-1:0]  cap_reg [NC];
    logic [AB-1:0]  sums_reg [NC];
    logic [AB-1:0]  sums_next [NC];
    logic [AB-1:0]  p_reg, p_next;
    logic [NI-1:0]  g_reg, g_next;
    logic [NI-1:0]  live;
    logic           act_valid_reg, act_back_reg;
    logic [mker_pkg::ITEM_BITS-1:0] act_idx_reg;
    logic           exceeded, take, item_ok;
    logic [VB-1:0]  wr_value;
    logic [mker_pkg::FIT_BITS-1:0] fit_sat;
    logic           rsp_valid_reg;
    mker_pkg::rsp_t rsp_reg;

    assign wr_value = VB'(req.load_value);
    assign item_ok  = (32'(req.item_index) < NI);

    mker_ram #(.WIDTH(VB), .DEPTH(NI)) u_profit (
        .clk   (clk),
        .we    (cmd.load && req.kind == mker_pkg::KIND_LOAD_PROFIT && item_ok),
        .waddr (req.item_index[mker_pkg::ITEM_BITS-1:0]),
        .wdata (wr_value),
        .raddr (cmd.addr),
        .rdata (p_rd)
    );

    for (genvar c = 0; c < NC; c++)
    begin : g_weight
        mker_ram #(.WIDTH(VB), .DEPTH(NI)) u_weight (
            .clk   (clk),
            .we    (cmd.load && req.kind == mker_pkg::KIND_LOAD_WEIGHT && item_ok &&
                    32'(req.constraint_index) == c),
            .waddr (req.item_index[mker_pkg::ITEM_BITS-1:0]),
            .wdata (wr_value),
            .raddr (cmd.addr),
            .rdata (w_rd[c])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (cmd.load && req.kind == mker_pkg::KIND_LOAD_CAP &&
                32'(req.constraint_index) == c)
            begin
                cap_reg[c] <= wr_value;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NI; j++)
        begin
            live[j] = (mker_pkg::ITEM_CNT_BITS'(j) < cmd.ni);
        end
    end

    // A constraint is exceeded when its sum passes its capacity; unused ones are ignored.
    always_comb
    begin
        exceeded = 1'b0;
        for (int c = 0; c < NC; c++)
        begin
            if (mker_pkg::CONS_CNT_BITS'(c) < cmd.nc && sums_reg[c] > AB'(cap_reg[c]))
            begin
                exceeded = 1'b1;
            end
        end
    end

    always_comb
    begin
        take      = act_valid_reg && g_reg[act_idx_reg] && (!act_back_reg || exceeded);
        g_next    = g_reg;
        p_next    = p_reg;
        sums_next = sums_reg;
        if (cmd.start)
        begin
            g_next = req.genes[NI-1:0] & live;
            p_next = '0;
            for (int c = 0; c < NC; c++)
            begin
                sums_next[c] = '0;
            end
        end
        else if (take)
        begin
            if (act_back_reg)
            begin
                g_next[act_idx_reg] = 1'b0;
                p_next = p_reg - AB'(p_rd);
                for (int c = 0; c < NC; c++)
                begin
                    sums_next[c] = sums_reg[c] - AB'(w_rd[c]);
                end
            end
            else
            begin
                p_next = p_reg + AB'(p_rd);
                for (int c = 0; c < NC; c++)
                begin
                    sums_next[c] = sums_reg[c] + AB'(w_rd[c]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg       <= g_next;
        p_reg       <= p_next;
        sums_reg    <= sums_next;
        act_back_reg <= cmd.back;
        act_idx_reg <= cmd.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_valid_reg <= 1'b0;
        else
            act_valid_reg <= cmd.issue;
    end

    assign fit_sat = (p_reg > AB'(mker_pkg::FIT_MAX)) ? mker_pkg::FIT_MAX
                                                      : p_reg[mker_pkg::FIT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.finish)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.fitness        <= exceeded ? '0 : fit_sat;
            rsp_reg.feasible       <= !exceeded;
            rsp_reg.repaired_genes <= cmd.repair ? 64'(g_reg) : '0;
        end
    end

    assign sts.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule
`default_nettype wire

### sv/multi_knapsack_evaluate_repair_core.sv
// Top level of the multidimensional knapsack evaluate/repair core.
// Depends on mker_pkg, mker_ctrl, mker_dp and mker_ram.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  mker_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall  mker_pkg::rsp_t
//   cfg      in         cfg_we (no wait)     cfg_index, cfg_data
//
// A load transaction is written while the core stays idle. An evaluate runs a forward
// pass and a repair adds a backward pass, with one table entry read per item on a single
// read port: a forward pass sums all constraints in parallel, a backward pass drops genes.
// Reset is asynchronous and active low; the tables hold no reset state and are loaded
// before use. A stalled result holds in the output register, and the next transaction
// is still accepted; only finishing a further result waits for that register to drain.
`timescale 1ns / 1ps
`default_nettype none
module multi_knapsack_evaluate_repair_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire mker_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output mker_pkg::rsp_t      rsp,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [6:0]     cfg_data
);

    // The controller sequences the passes and owns the configuration; the datapath
    // holds the tables and the running sums, and talks back only through status.
    mker_pkg::cmd_t cmd;
    mker_pkg::sts_t sts;

    mker_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    mker_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

### sv/mker_checker.sv
// Port-level checks of the knapsack core, bound to its top level.
// Depends on mker_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_knapsack_evaluate_repair_core_macros.svh"
module mker_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire mker_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire mker_pkg::rsp_t rsp
);

    `MKER_ASSERT_NXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)
    `MKER_ASSERT_IMP(a_infeasible_zero, rsp_valid && !rsp.feasible, rsp.fitness == '0)
    `MKER_ASSERT_IMP(a_repair_feasible, rsp_valid && rsp.repaired_genes != '0, rsp.feasible)
    `MKER_ASSERT_NXT(a_busy_after_start,
        req_valid && !req_stall &&
        (req.kind == mker_pkg::KIND_EVALUATE || req.kind == mker_pkg::KIND_REPAIR),
        req_stall)

endmodule

bind multi_knapsack_evaluate_repair_core mker_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire
